### src/recwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recwl_pkg
// Types and constants shared by the rotary encoder colour wheel LED block.
// ----------------------------------------------------------------------------
package recwl_pkg;

    localparam int POS_W = 8;
    localparam logic signed [POS_W-1:0] POS_MIN = -8'sd99;
    localparam logic signed [POS_W-1:0] POS_MAX = 8'sd99;

    // floor(u * 767 / 198) as (u * WHEEL_MUL) >> WHEEL_SHIFT, exact for u in 0..198
    localparam int WHEEL_SHIFT = 20;
    localparam int WHEEL_MUL_W = 22;
    localparam int WHEEL_PROD_W = 30;
    localparam logic [WHEEL_MUL_W-1:0] WHEEL_MUL = 22'd4061909;
    localparam int WHEEL_IDX_W = 10;

    localparam int GAP_W = 16;
    localparam int TIME_W = 32;
    localparam logic [GAP_W-1:0] GAP_RESET = 16'd50;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } t_step_dir;

    typedef struct packed {
        logic              clk_level;
        logic              dt_level;
        logic              button_level;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0]              red;
        logic [7:0]              green;
        logic [7:0]              blue;
        logic                    led_on;
        logic signed [POS_W-1:0] position;
        t_step_dir               step_dir;
        logic                    press_seen;
    } t_out_item;

endpackage

### src/recwl_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recwl_wheel
// Maps a saturated encoder position onto a red-green-blue colour wheel.
// ----------------------------------------------------------------------------
module recwl_wheel
    import recwl_pkg::*;
(
    input  logic signed [POS_W-1:0] i_pos,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue
);

    logic [POS_W:0]          w_sum;
    logic [POS_W-1:0]        w_offset;
    logic [WHEEL_PROD_W-1:0] w_prod;
    logic [WHEEL_IDX_W-1:0]  w_idx;

    assign w_sum    = {i_pos[POS_W-1], i_pos} - {POS_MIN[POS_W-1], POS_MIN};
    assign w_offset = w_sum[POS_W-1:0];
    assign w_prod   = WHEEL_PROD_W'(w_offset) * WHEEL_PROD_W'(WHEEL_MUL);
    assign w_idx    = w_prod[WHEEL_SHIFT +: WHEEL_IDX_W];

    always_comb begin
        case (w_idx[9:8])
            2'd0: begin
                o_red   = ~w_idx[7:0];
                o_green = w_idx[7:0];
                o_blue  = 8'd0;
            end
            2'd1: begin
                o_red   = 8'd0;
                o_green = ~w_idx[7:0];
                o_blue  = w_idx[7:0];
            end
            2'd2: begin
                o_red   = w_idx[7:0];
                o_green = 8'd0;
                o_blue  = ~w_idx[7:0];
            end
            default: begin
                o_red   = 8'd0;
                o_green = 8'd0;
                o_blue  = 8'd0;
            end
        endcase
    end

endmodule

### src/recwl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recwl_core
// Encoder, button and LED state with the per-item update logic.
// ----------------------------------------------------------------------------
module recwl_core
    import recwl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_in_item         i_item,
    input  logic [GAP_W-1:0] i_press_gap,
    output t_out_item        o_result
);

    logic                    r_last_clk;
    logic signed [POS_W-1:0] r_pos;
    logic [TIME_W-1:0]       r_last_low;
    logic                    r_led;
    logic [7:0]              r_red;
    logic [7:0]              r_green;
    logic [7:0]              r_blue;

    logic signed [POS_W-1:0] n_pos;
    logic [TIME_W-1:0]       n_last_low;
    logic                    n_led;
    logic [7:0]              n_red;
    logic [7:0]              n_green;
    logic [7:0]              n_blue;

    logic                    w_rising;
    logic                    w_press;
    logic                    w_led_rot;
    logic [TIME_W-1:0]       w_elapsed;
    logic [7:0]              w_red;
    logic [7:0]              w_green;
    logic [7:0]              w_blue;
    t_step_dir               w_dir;

    recwl_wheel u_wheel (
        .i_pos   (n_pos),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign w_rising  = i_item.clk_level & ~r_last_clk;
    assign w_elapsed = i_item.now_ms - r_last_low;
    assign w_press   = ~i_item.button_level && (w_elapsed > TIME_W'(i_press_gap));

    always_comb begin
        n_pos = r_pos;
        w_dir = STEP_NONE;
        if (w_rising) begin
            if (i_item.dt_level != i_item.clk_level) begin
                w_dir = STEP_CCW;
                if (r_pos > POS_MIN) begin
                    n_pos = r_pos - 8'sd1;
                end
            end else begin
                w_dir = STEP_CW;
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 8'sd1;
                end
            end
        end
    end

    always_comb begin
        w_led_rot = w_rising ? 1'b1 : r_led;
        n_led     = w_led_rot;
        n_red     = w_rising ? w_red : r_red;
        n_green   = w_rising ? w_green : r_green;
        n_blue    = w_rising ? w_blue : r_blue;
        if (w_press) begin
            if (w_led_rot) begin
                n_led   = 1'b0;
                n_red   = 8'd0;
                n_green = 8'd0;
                n_blue  = 8'd0;
            end else begin
                n_led   = 1'b1;
                n_red   = 8'd255;
                n_green = 8'd255;
                n_blue  = 8'd255;
            end
        end
        n_last_low = i_item.button_level ? r_last_low : i_item.now_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_clk <= 1'b1;
            r_pos      <= '0;
            r_last_low <= '0;
            r_led      <= 1'b0;
            r_red      <= '0;
            r_green    <= '0;
            r_blue     <= '0;
        end else if (i_fire) begin
            r_last_clk <= i_item.clk_level;
            r_pos      <= n_pos;
            r_last_low <= n_last_low;
            r_led      <= n_led;
            r_red      <= n_red;
            r_green    <= n_green;
            r_blue     <= n_blue;
        end
    end

    always_comb begin
        o_result.red        = n_red;
        o_result.green      = n_green;
        o_result.blue       = n_blue;
        o_result.led_on     = n_led;
        o_result.position   = n_pos;
        o_result.step_dir   = w_dir;
        o_result.press_seen = w_press;
    end

endmodule

### src/rotary_encoder_color_wheel_led.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_color_wheel_led
// Rotary encoder and push button poll samples drive a colour wheel LED.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_item (t_out_item)
// cfg       input      i_cfg_we                   i_cfg_wdata (press gap, ms)
//
// One item per cycle sustained while the result is not stalled; an accepted item
// passes the input register, then the result register. The path between them
// (position step, one constant multiply, gap compare) is combinational.
// Synchronous active-low reset; the press gap resets to 50 ms.
// A stalled result holds the result register; one more item waits in the
// input register, then o_in_ready drops.
// ----------------------------------------------------------------------------
module rotary_encoder_color_wheel_led
    import recwl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [GAP_W-1:0] i_cfg_wdata
);

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic [GAP_W-1:0] r_press_gap;

    logic             w_advance;
    logic             w_fire;
    t_out_item        w_result;

    assign w_advance   = ~r_out_valid | i_out_ready;
    assign w_fire      = r_in_valid & w_advance;
    assign o_in_ready  = ~r_in_valid | w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    recwl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in_item),
        .i_press_gap (r_press_gap),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_press_gap <= GAP_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                r_press_gap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

endmodule

### tb/sv/rotary_encoder_color_wheel_led_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_color_wheel_led_tb
// Self-checking bench for the rotary encoder colour wheel LED block. Encoder
// and button poll samples go in through a queued driver; every result is
// checked field by field against an in-bench model of the position counter,
// colour wheel and press toggle. Phases vary the press gap and the idling of
// both channels.
// ----------------------------------------------------------------------------
module rotary_encoder_color_wheel_led_tb;
    import recwl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    t_in_item         in_item = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we = 1'b0;
    logic [GAP_W-1:0] cfg_wdata = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_item        o_out_item;

    rotary_encoder_color_wheel_led u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // pending samples and expected wheel results
    t_in_item  sample_pending_q[$];
    t_out_item wheel_expected_q[$];
    logic      in_taken = 1'b0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        fail_count = 0;
    int        cycle_count = 0;

    // wheel model state
    logic [GAP_W-1:0]  gap_ms = GAP_RESET;
    logic              wheel_last_clk = 1'b1;
    int                wheel_pos = 0;
    logic [TIME_W-1:0] wheel_last_low = '0;
    logic              wheel_led = 1'b0;
    logic [7:0]        wheel_red = '0;
    logic [7:0]        wheel_green = '0;
    logic [7:0]        wheel_blue = '0;

    // stimulus generator bookkeeping
    logic [TIME_W-1:0] gen_now = '0;
    logic [TIME_W-1:0] gen_last_low = '0;
    logic [GAP_W-1:0]  gen_gap = GAP_RESET;

    task automatic report_fail(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic predict_wheel(input t_in_item it, output t_out_item res);
        int                c;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        res.step_dir = STEP_NONE;
        if (it.clk_level && !wheel_last_clk) begin
            if (it.dt_level != it.clk_level) begin
                res.step_dir = STEP_CCW;
                if (wheel_pos > -99) wheel_pos--;
            end else begin
                res.step_dir = STEP_CW;
                if (wheel_pos < 99) wheel_pos++;
            end
            c = (wheel_pos + 99) * 767 / 198;
            if (c <= 255) begin
                wheel_red = 8'(255 - c);
                wheel_green = 8'(c);
                wheel_blue = 8'd0;
            end else if (c <= 511) begin
                wheel_red = 8'd0;
                wheel_green = 8'(255 - (c - 256));
                wheel_blue = 8'(c - 256);
            end else begin
                wheel_red = 8'(c - 512);
                wheel_green = 8'd0;
                wheel_blue = 8'(255 - (c - 512));
            end
            wheel_led = 1'b1;
        end
        wheel_last_clk = it.clk_level;
        if (!it.button_level) begin
            elapsed = it.now_ms - wheel_last_low;
            if (elapsed > TIME_W'(gap_ms)) begin
                wheel_led = ~wheel_led;
                wheel_red = wheel_led ? 8'd255 : 8'd0;
                wheel_green = wheel_led ? 8'd255 : 8'd0;
                wheel_blue = wheel_led ? 8'd255 : 8'd0;
                res.press_seen = 1'b1;
            end
            wheel_last_low = it.now_ms;
        end
        res.red = wheel_red;
        res.green = wheel_green;
        res.blue = wheel_blue;
        res.led_on = wheel_led;
        res.position = POS_W'(wheel_pos);
    endtask

    // driver: hold the item until taken, then offer the next one
    always @(negedge i_clk) begin
        t_in_item nxt_item;
        logic     nxt_valid;
        nxt_item = in_item;
        nxt_valid = in_valid;
        if (!in_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (sample_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt_item = sample_pending_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        in_item <= nxt_item;
        in_valid <= nxt_valid;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: check results, predict accepted items, track the register
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        in_taken <= in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                got = o_out_item;
                if (wheel_expected_q.size() == 0) begin
                    report_fail("result with nothing expected");
                end else begin
                    want = wheel_expected_q.pop_front();
                    if (got.red !== want.red)
                        report_fail($sformatf("red %0d, expected %0d", got.red, want.red));
                    if (got.green !== want.green)
                        report_fail($sformatf("green %0d, expected %0d",
                                              got.green, want.green));
                    if (got.blue !== want.blue)
                        report_fail($sformatf("blue %0d, expected %0d", got.blue, want.blue));
                    if (got.led_on !== want.led_on)
                        report_fail($sformatf("led_on %0d, expected %0d",
                                              got.led_on, want.led_on));
                    if (got.position !== want.position)
                        report_fail($sformatf("position %0d, expected %0d",
                                              got.position, want.position));
                    if (got.step_dir !== want.step_dir)
                        report_fail($sformatf("step_dir %0d, expected %0d",
                                              got.step_dir, want.step_dir));
                    if (got.press_seen !== want.press_seen)
                        report_fail($sformatf("press_seen %0d, expected %0d",
                                              got.press_seen, want.press_seen));
                end
            end
            if (in_valid && o_in_ready) begin
                predict_wheel(in_item, want);
                wheel_expected_q.push_back(want);
            end
            if (cfg_we) gap_ms = cfg_wdata;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[rotary_encoder_color_wheel_led] ERROR");
            $finish;
        end
    end

    task automatic push_raw(input t_in_item it);
        if (!it.button_level) gen_last_low = it.now_ms;
        sample_pending_q.push_back(it);
    endtask

    task automatic push_sample(input logic clk_l, input logic dt_l, input logic btn_l);
        t_in_item it;
        it.clk_level = clk_l;
        it.dt_level = dt_l;
        it.button_level = btn_l;
        if (btn_l) begin
            gen_now = gen_now + $urandom_range(0, 4);
        end else begin
            case ($urandom_range(0, 5))
                0: gen_now = gen_last_low + TIME_W'(gen_gap);
                1: gen_now = gen_last_low + TIME_W'(gen_gap) + 32'd1;
                2: gen_now = gen_last_low + TIME_W'(gen_gap) - 32'd1;
                3: gen_now = gen_last_low + $urandom_range(0, 3);
                4: gen_now = gen_last_low + $urandom();
                default: gen_now = gen_now + $urandom_range(0, 3);
            endcase
        end
        it.now_ms = gen_now;
        push_raw(it);
    endtask

    task automatic push_fixed(input logic clk_l, input logic dt_l, input logic btn_l,
                              input logic [TIME_W-1:0] t);
        t_in_item it;
        it.clk_level = clk_l;
        it.dt_level = dt_l;
        it.button_level = btn_l;
        it.now_ms = t;
        push_raw(it);
    endtask

    task automatic wait_drain();
        do @(negedge i_clk);
        while (sample_pending_q.size() != 0 || in_valid || wheel_expected_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] v);
        wait_drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        gen_gap = v;
    endtask

    task automatic gen_random(input int n_items);
        int       made;
        int       pairs;
        int       k;
        int       kind;
        logic     dir_bit;
        t_in_item it;
        made = 0;
        while (made < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                // a run of detent steps in one direction
                pairs = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 130)
                                                   : $urandom_range(1, 30);
                dir_bit = 1'($urandom_range(0, 1));
                for (k = 0; k < pairs; k++) begin
                    push_sample(1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
                    push_sample(1'b1, dir_bit, $urandom_range(0, 9) != 0);
                end
                made += 2 * pairs;
            end else if (kind < 85) begin
                pairs = $urandom_range(1, 6);
                for (k = 0; k < pairs; k++)
                    push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 3) == 0);
                made += pairs;
            end else if (kind < 95) begin
                it = {3'($urandom_range(0, 7)), $urandom()};
                push_raw(it);
                made++;
            end else begin
                gen_now = $urandom();
            end
            // pause until every expected result is in
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
    endtask

    initial begin
        int idle_tab[5];
        int stall_tab[5];
        int ph;
        idle_tab = '{0, 45, 0, 8, 0};
        stall_tab = '{0, 0, 45, 8, 0};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: steps both ways, gap boundary, timestamp wrap, all-ones fields
        push_fixed(1'b1, 1'b1, 1'b1, 32'd0);
        push_fixed(1'b0, 1'b0, 1'b1, 32'd1);
        push_fixed(1'b1, 1'b1, 1'b1, 32'd2);
        push_fixed(1'b0, 1'b1, 1'b1, 32'd3);
        push_fixed(1'b1, 1'b0, 1'b1, 32'd4);
        push_fixed(1'b0, 1'b0, 1'b1, 32'd5);
        push_fixed(1'b1, 1'b0, 1'b1, 32'd6);
        push_fixed(1'b1, 1'b0, 1'b0, 32'd50);
        push_fixed(1'b1, 1'b0, 1'b0, 32'd101);
        push_fixed(1'b1, 1'b0, 1'b0, 32'd102);
        push_fixed(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
        push_fixed(1'b1, 1'b0, 1'b0, 32'h0000_0040);
        push_fixed(1'b0, 1'b0, 1'b1, 32'h0000_0041);
        push_fixed(1'b1, 1'b1, 1'b0, 32'h0000_0074);
        push_fixed(1'b0, 1'b0, 1'b1, 32'h0000_0075);
        push_fixed(1'b1, 1'b0, 1'b0, 32'h0000_00A8);
        push_fixed(1'b0, 1'b1, 1'b0, 32'h0000_00A9);
        push_fixed(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_fixed(1'b0, 1'b0, 1'b0, 32'h0000_0000);
        push_fixed(1'b1, 1'b1, 1'b0, 32'h8000_0000);
        gen_now = 32'h8000_0000;
        wait_drain();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_gap(16'd0);
                1: write_gap(16'hFFFF);
                2: write_gap(16'($urandom_range(2, 300)));
                3: write_gap(16'd1);
                default: write_gap(16'($urandom()));
            endcase
            send_idle_pct = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            gen_random(370);
        end
        write_gap(GAP_RESET);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        gen_random(40);
        wait_drain();

        if (fail_count == 0) begin
            $display("[rotary_encoder_color_wheel_led] OK");
        end else begin
            $display("[rotary_encoder_color_wheel_led] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
src/recwl_pkg.sv
src/recwl_wheel.sv
src/recwl_core.sv
src/rotary_encoder_color_wheel_led.sv
tb/sv/rotary_encoder_color_wheel_led_tb.sv
